@@ hdl/scp_pkg.sv @@
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants for segment_closest_point
// Request payload structs, region codes and the division cell record.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int VEC_WIDTH     = COORD_WIDTH + 1;        // v and d
    localparam int DIV_WIDTH     = 2 * COORD_WIDTH + 3;    // num, den, remainder

    typedef enum logic [1:0] {
        REGION_START    = 2'd0,
        REGION_INTERIOR = 2'd1,
        REGION_END      = 2'd2,
        REGION_ZERO     = 2'd3
    } region_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic signed [COORD_WIDTH-1:0] seg_start_x;
        logic signed [COORD_WIDTH-1:0] seg_start_y;
        logic signed [COORD_WIDTH-1:0] seg_start_z;
        logic signed [COORD_WIDTH-1:0] seg_end_x;
        logic signed [COORD_WIDTH-1:0] seg_end_y;
        logic signed [COORD_WIDTH-1:0] seg_end_z;
    } in_req_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] nearest_x;
        logic signed [COORD_WIDTH-1:0] nearest_y;
        logic signed [COORD_WIDTH-1:0] nearest_z;
        logic        [1:0]             region;
    } out_req_t;

    // Record handed from one division cell to the next
    typedef struct packed {
        logic                                valid;
        logic [DIV_WIDTH-1:0]                rem;
        logic [DIV_WIDTH-1:0]                den;
        logic [FRACTION_BITS-1:0]            t;
        region_t                             region;
        logic [2:0][COORD_WIDTH-1:0]         s;
        logic [2:0][COORD_WIDTH-1:0]         e;
        logic [2:0][VEC_WIDTH-1:0]           d;
    } div_rec_t;

endpackage

`default_nettype wire

@@ hdl/scp_cell.sv @@
// ----------------------------------------------------------------------------
// scp_cell: one restoring division step
// Shifts the remainder, produces one quotient bit of t, passes the request on.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire scp_pkg::div_rec_t rec_in,
    output scp_pkg::div_rec_t      rec_out
);

    localparam int DW = scp_pkg::DIV_WIDTH;
    localparam int FB = scp_pkg::FRACTION_BITS;

    scp_pkg::div_rec_t rec_reg, rec_next;
    logic        valid_reg;
    logic [DW:0] shifted;
    logic [DW:0] diff;
    logic        ge;

    // one quotient bit
    always_comb
    begin
        shifted  = {rec_in.rem, 1'b0};
        diff     = shifted - {1'b0, rec_in.den};
        ge       = (shifted >= {1'b0, rec_in.den});
        rec_next = rec_in;
        rec_next.rem = ge ? diff[DW-1:0] : shifted[DW-1:0];
        rec_next.t   = {rec_in.t[FB-2:0], ge};
    end

    // valid resets, payload does not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= rec_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rec_reg <= rec_next;
        end
    end

    always_comb
    begin
        rec_out       = rec_reg;
        rec_out.valid = valid_reg;
    end

endmodule

`default_nettype wire

@@ hdl/segment_closest_point.sv @@
// ----------------------------------------------------------------------------
// segment_closest_point: closest point on a 3D segment
// Pipelined projection with a chain of restoring division cells for t.
// ----------------------------------------------------------------------------
//  channel | signals                     | payload
//  in      | in_valid, in_stall, in_data | scp_pkg::in_req_t (point, start, end)
//  out     | out_valid, out_stall, out_data | scp_pkg::out_req_t (nearest, region)
//
//  One request per cycle while the output is not stalled; the stages are input,
//  products, sums with classify, one division cell per bit of t, offset product
//  and output. The whole pipeline advances together; it holds while the output
//  request is stalled, and in_stall then rises. Reset clears only valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_closest_point (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire scp_pkg::in_req_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output scp_pkg::out_req_t     out_data
);

    localparam int CW = scp_pkg::COORD_WIDTH;
    localparam int FB = scp_pkg::FRACTION_BITS;
    localparam int VW = scp_pkg::VEC_WIDTH;
    localparam int DW = scp_pkg::DIV_WIDTH;
    localparam int PW = 2 * VW;
    localparam int MW = VW + FB + 1;

    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // ---- stage A: differences
    logic                          a_valid_reg;
    logic signed [2:0][VW-1:0]     a_v_reg, a_d_reg;
    logic        [2:0][CW-1:0]     a_s_reg, a_e_reg;
    logic        [2:0][CW-1:0]     p_in, s_in, e_in;

    assign p_in = {in_data.point_z, in_data.point_y, in_data.point_x};
    assign s_in = {in_data.seg_start_z, in_data.seg_start_y, in_data.seg_start_x};
    assign e_in = {in_data.seg_end_z, in_data.seg_end_y, in_data.seg_end_x};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_v_reg[i] <= {p_in[i][CW-1], p_in[i]} - {s_in[i][CW-1], s_in[i]};
                a_d_reg[i] <= {e_in[i][CW-1], e_in[i]} - {s_in[i][CW-1], s_in[i]};
            end
            a_s_reg <= s_in;
            a_e_reg <= e_in;
        end
    end

    // ---- stage B: products
    logic                          b_valid_reg;
    logic        [2:0][PW-1:0]     b_pn_reg, b_pd_reg;
    logic        [2:0][CW-1:0]     b_s_reg, b_e_reg;
    logic        [2:0][VW-1:0]     b_d_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                b_pn_reg[i] <= $signed(a_v_reg[i]) * $signed(a_d_reg[i]);
                b_pd_reg[i] <= $signed(a_d_reg[i]) * $signed(a_d_reg[i]);
            end
            b_s_reg <= a_s_reg;
            b_e_reg <= a_e_reg;
            b_d_reg <= a_d_reg;
        end
    end

    // ---- stage C: dot products
    logic                          c_valid_reg;
    logic signed [DW-1:0]          c_num_reg, c_den_reg;
    logic        [2:0][CW-1:0]     c_s_reg, c_e_reg;
    logic        [2:0][VW-1:0]     c_d_reg;
    logic signed [2:0][DW-1:0]     pn_ext, pd_ext;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pn_ext[i] = {{(DW-PW){b_pn_reg[i][PW-1]}}, b_pn_reg[i]};
            pd_ext[i] = {{(DW-PW){b_pd_reg[i][PW-1]}}, b_pd_reg[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_num_reg <= pn_ext[0] + pn_ext[1] + pn_ext[2];
            c_den_reg <= pd_ext[0] + pd_ext[1] + pd_ext[2];
            c_s_reg   <= b_s_reg;
            c_e_reg   <= b_e_reg;
            c_d_reg   <= b_d_reg;
        end
    end

    // ---- classify, feeds the division chain
    scp_pkg::div_rec_t chain [FB+1];

    always_comb
    begin
        chain[0].valid = c_valid_reg;
        chain[0].rem   = c_num_reg;
        chain[0].den   = c_den_reg;
        chain[0].t     = '0;
        chain[0].s     = c_s_reg;
        chain[0].e     = c_e_reg;
        chain[0].d     = c_d_reg;
        priority if (c_den_reg == '0)
            chain[0].region = scp_pkg::REGION_ZERO;
        else if (c_num_reg <= $signed(DW'(0)))
            chain[0].region = scp_pkg::REGION_START;
        else if (c_num_reg >= c_den_reg)
            chain[0].region = scp_pkg::REGION_END;
        else
            chain[0].region = scp_pkg::REGION_INTERIOR;
    end

    for (genvar g = 0; g < FB; g++)
    begin : g_cell
        scp_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .rec_in  (chain[g]),
            .rec_out (chain[g+1])
        );
    end

    // ---- stage M: offset products t * d
    logic                          m_valid_reg;
    logic signed [2:0][MW-1:0]     m_off_reg;
    logic        [2:0][CW-1:0]     m_s_reg, m_e_reg;
    scp_pkg::region_t              m_region_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_off_reg[i] <= $signed({1'b0, chain[FB].t}) * $signed(chain[FB].d[i]);
            end
            m_s_reg      <= chain[FB].s;
            m_e_reg      <= chain[FB].e;
            m_region_reg <= chain[FB].region;
        end
    end

    // ---- output register
    logic                          out_valid_reg;
    scp_pkg::out_req_t             out_data_reg, out_data_next;
    logic        [2:0][CW-1:0]     res;
    logic signed [MW-1:0]          off_sh;

    always_comb
    begin
        off_sh = '0;
        for (int i = 0; i < 3; i++)
        begin
            off_sh = $signed(m_off_reg[i]) >>> FB;
            unique case (m_region_reg)
                scp_pkg::REGION_INTERIOR: res[i] = m_s_reg[i] + off_sh[CW-1:0];
                scp_pkg::REGION_END:      res[i] = m_e_reg[i];
                default:                  res[i] = m_s_reg[i];
            endcase
        end
        out_data_next.nearest_x = res[0];
        out_data_next.nearest_y = res[1];
        out_data_next.nearest_z = res[2];
        out_data_next.region    = m_region_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // ---- valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            m_valid_reg   <= chain[FB].valid;
            out_valid_reg <= m_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---- assertions
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall not tied to a held output request");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> a_valid_reg)
        else $error("accepted request lost at first stage");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !in_stall) |=> out_valid)
        else $error("offset stage request not delivered");

endmodule

`default_nettype wire
